// ----- rtl/mpei_pkg.sv -----
// shared types, constants and helpers of the mass point integrator
// no dependencies, compiled first

package mpei_pkg;

    localparam int MPEI_FRAC_BITS = 16;
    localparam int AXES           = 3;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    // register indexes (byte address is index times four)
    localparam logic [1:0] REG_TIME_STEP     = 2'd0;
    localparam logic [1:0] REG_STEP_PER_MASS = 2'd1;
    localparam logic [1:0] REG_INVERSE_STEP  = 2'd2;
    localparam logic [1:0] REG_FLOOR_HEIGHT  = 2'd3;

    localparam logic [30:0]        TIME_STEP_RST     = 31'd655;
    localparam logic [30:0]        STEP_PER_MASS_RST = 31'd655;
    localparam logic [30:0]        INVERSE_STEP_RST  = 31'd6553600;
    localparam logic signed [31:0] FLOOR_HEIGHT_RST  = 32'shFFFF_0000;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // multiplier operand selects
    localparam logic [1:0] MSEL_F_SPM   = 2'd0;
    localparam logic [1:0] MSEL_V_TS    = 2'd1;
    localparam logic [1:0] MSEL_GAP_INV = 2'd2;

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_BOX   = 1'b1;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic               first_point;
        logic               last_point;
        logic signed [31:0] force_x;
        logic signed [31:0] force_y;
        logic signed [31:0] force_z;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } point_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic               run_end;
    } result_t;

    typedef struct packed {
        logic [30:0]        time_step;
        logic [30:0]        step_per_mass;
        logic [30:0]        inverse_step;
        logic signed [31:0] floor_height;
    } cfg_t;

    // controller to datapath commands
    typedef struct packed {
        logic       load;
        logic       mul_en;
        logic [1:0] mul_sel;
        logic [1:0] mul_axis;
        logic       wr_nv;
        logic       wr_np;
        logic [1:0] wr_axis;
        logic       wr_gap;
        logic       fix_vy;
        logic       out_pt;
        logic       out_box;
        logic       pt_end;
    } dp_cmd_t;

    // saturate a wide signed value to 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [64:0] x);
        logic signed [31:0] r;
        if ((&x[64:31]) || (~|x[64:31]))
        begin
            r = x[31:0];
        end
        else if (x[64])
        begin
            r = S32_MIN;
        end
        else
        begin
            r = S32_MAX;
        end
        return r;
    endfunction

endpackage

// ----- rtl/mpei_stream_if.sv -----
// valid/ready channel carrying one item of a packed payload type
// depends on nothing but the payload type handed in

interface mpei_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/mpei_cfg.sv -----
// apb-style configuration registers of the mass point integrator
// depends on mpei_pkg

module mpei_cfg
    import mpei_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_TIME_STEP:     cfg_next.time_step     = pwdata[30:0];
                REG_STEP_PER_MASS: cfg_next.step_per_mass = pwdata[30:0];
                REG_INVERSE_STEP:  cfg_next.inverse_step  = pwdata[30:0];
                REG_FLOOR_HEIGHT:  cfg_next.floor_height  = pwdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.time_step     <= TIME_STEP_RST;
            cfg_reg.step_per_mass <= STEP_PER_MASS_RST;
            cfg_reg.inverse_step  <= INVERSE_STEP_RST;
            cfg_reg.floor_height  <= FLOOR_HEIGHT_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_TIME_STEP:     prdata = {1'b0, cfg_reg.time_step};
            REG_STEP_PER_MASS: prdata = {1'b0, cfg_reg.step_per_mass};
            REG_INVERSE_STEP:  prdata = {1'b0, cfg_reg.inverse_step};
            REG_FLOOR_HEIGHT:  prdata = cfg_reg.floor_height;
            default:           prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/mpei_ctrl.sv -----
// sequencer of the mass point integrator: steps the shared multiplier
// and owns the input and output handshakes; depends on mpei_pkg

module mpei_ctrl
    import mpei_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_last,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output dp_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_LOAD = 2'd2;
    localparam logic [1:0] ST_BOX  = 2'd3;

    localparam logic [3:0] STEP_MUL_FX  = 4'd0;
    localparam logic [3:0] STEP_NV_X    = 4'd1;
    localparam logic [3:0] STEP_NV_Y    = 4'd2;
    localparam logic [3:0] STEP_NV_Z    = 4'd3;
    localparam logic [3:0] STEP_NP_X    = 4'd4;
    localparam logic [3:0] STEP_NP_Y    = 4'd5;
    localparam logic [3:0] STEP_NP_Z    = 4'd6;
    localparam logic [3:0] STEP_MUL_GAP = 4'd7;
    localparam logic [3:0] STEP_FIX     = 4'd8;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       last_reg;
    logic       last_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;
    dp_cmd_t    step_cmd;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    // per-step multiplier and write-back schedule
    always_comb
    begin
        step_cmd = '0;
        unique case (step_reg)
            STEP_MUL_FX:
            begin
                step_cmd.mul_en   = 1'b1;
                step_cmd.mul_sel  = MSEL_F_SPM;
                step_cmd.mul_axis = AXIS_X;
            end
            STEP_NV_X:
            begin
                step_cmd.wr_nv    = 1'b1;
                step_cmd.wr_axis  = AXIS_X;
                step_cmd.mul_en   = 1'b1;
                step_cmd.mul_sel  = MSEL_F_SPM;
                step_cmd.mul_axis = AXIS_Y;
            end
            STEP_NV_Y:
            begin
                step_cmd.wr_nv    = 1'b1;
                step_cmd.wr_axis  = AXIS_Y;
                step_cmd.mul_en   = 1'b1;
                step_cmd.mul_sel  = MSEL_F_SPM;
                step_cmd.mul_axis = AXIS_Z;
            end
            STEP_NV_Z:
            begin
                step_cmd.wr_nv    = 1'b1;
                step_cmd.wr_axis  = AXIS_Z;
                step_cmd.mul_en   = 1'b1;
                step_cmd.mul_sel  = MSEL_V_TS;
                step_cmd.mul_axis = AXIS_X;
            end
            STEP_NP_X:
            begin
                step_cmd.wr_np    = 1'b1;
                step_cmd.wr_axis  = AXIS_X;
                step_cmd.mul_en   = 1'b1;
                step_cmd.mul_sel  = MSEL_V_TS;
                step_cmd.mul_axis = AXIS_Y;
            end
            STEP_NP_Y:
            begin
                step_cmd.wr_np    = 1'b1;
                step_cmd.wr_axis  = AXIS_Y;
                step_cmd.mul_en   = 1'b1;
                step_cmd.mul_sel  = MSEL_V_TS;
                step_cmd.mul_axis = AXIS_Z;
            end
            STEP_NP_Z:
            begin
                step_cmd.wr_np   = 1'b1;
                step_cmd.wr_axis = AXIS_Z;
                step_cmd.wr_gap  = 1'b1;
            end
            STEP_MUL_GAP:
            begin
                step_cmd.mul_en  = 1'b1;
                step_cmd.mul_sel = MSEL_GAP_INV;
            end
            STEP_FIX:
            begin
                step_cmd.fix_vy = 1'b1;
            end
            default:
            begin
                step_cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        last_next  = last_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    last_next  = in_last;
                    step_next  = STEP_MUL_FX;
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                cmd = step_cmd;
                if (step_reg == STEP_FIX)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    step_next = step_reg + 4'd1;
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    cmd.out_pt = 1'b1;
                    cmd.pt_end = !last_reg;
                    state_next = last_reg ? ST_BOX : ST_IDLE;
                end
            end
            ST_BOX:
            begin
                if (out_free)
                begin
                    cmd.out_box = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_pt || cmd.out_box)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STEP_MUL_FX;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/mpei_dp.sv -----
// datapath of the mass point integrator: operand registers, one shared
// multiplier, accumulate/saturate, floor test, box and output register
// depends on mpei_pkg

module mpei_dp
    import mpei_pkg::*;
#(
    parameter int FRAC_BITS = MPEI_FRAC_BITS
) (
    input  logic    clk,
    input  logic    rst_n,
    input  dp_cmd_t cmd,
    input  point_t  pt,
    input  cfg_t    cfg,
    output result_t res
);

    logic signed [31:0] f_reg  [AXES];
    logic signed [31:0] v_reg  [AXES];
    logic signed [31:0] p_reg  [AXES];
    logic signed [31:0] nv_reg [AXES];
    logic signed [31:0] np_reg [AXES];
    logic signed [31:0] lo_reg [AXES];
    logic signed [31:0] hi_reg [AXES];
    logic signed [32:0] gap_reg;
    logic               below_reg;
    logic signed [64:0] prod_reg;
    result_t            res_reg;

    logic signed [32:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [64:0] shifted;
    logic signed [31:0] acc_base;
    logic signed [64:0] acc_sum;
    logic signed [31:0] acc_sat;
    logic signed [31:0] q_sat;
    logic signed [32:0] gap_next;

    always_comb
    begin
        unique case (cmd.mul_sel)
            MSEL_F_SPM:
            begin
                mul_a = {f_reg[cmd.mul_axis][31], f_reg[cmd.mul_axis]};
                mul_b = {1'b0, cfg.step_per_mass};
            end
            MSEL_V_TS:
            begin
                mul_a = {nv_reg[cmd.mul_axis][31], nv_reg[cmd.mul_axis]};
                mul_b = {1'b0, cfg.time_step};
            end
            MSEL_GAP_INV:
            begin
                mul_a = gap_reg;
                mul_b = {1'b0, cfg.inverse_step};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // product scaled back, rounding toward minus infinity
    assign shifted  = prod_reg >>> FRAC_BITS;
    assign acc_base = cmd.wr_np ? p_reg[cmd.wr_axis] : v_reg[cmd.wr_axis];
    assign acc_sum  = {{33{acc_base[31]}}, acc_base} + shifted;
    assign acc_sat  = sat32(acc_sum);
    // bounce velocity is never negative, clip at the top only
    assign q_sat    = (|shifted[64:31]) ? S32_MAX : shifted[31:0];
    assign gap_next = {cfg.floor_height[31], cfg.floor_height}
                    - {np_reg[AXIS_Y][31], np_reg[AXIS_Y]};

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            f_reg[AXIS_X] <= pt.force_x;
            f_reg[AXIS_Y] <= pt.force_y;
            f_reg[AXIS_Z] <= pt.force_z;
            v_reg[AXIS_X] <= pt.vel_x;
            v_reg[AXIS_Y] <= pt.vel_y;
            v_reg[AXIS_Z] <= pt.vel_z;
            p_reg[AXIS_X] <= pt.pos_x;
            p_reg[AXIS_Y] <= pt.pos_y;
            p_reg[AXIS_Z] <= pt.pos_z;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_a * mul_b;
        end
        if (cmd.wr_nv)
        begin
            nv_reg[cmd.wr_axis] <= acc_sat;
        end
        else if (cmd.fix_vy && below_reg)
        begin
            nv_reg[AXIS_Y] <= q_sat;
        end
        if (cmd.wr_np)
        begin
            np_reg[cmd.wr_axis] <= acc_sat;
        end
        if (cmd.wr_gap)
        begin
            gap_reg   <= gap_next;
            below_reg <= (np_reg[AXIS_Y] < cfg.floor_height);
        end
        if (cmd.out_pt)
        begin
            res_reg.result_kind <= KIND_POINT;
            res_reg.a_x         <= nv_reg[AXIS_X];
            res_reg.a_y         <= nv_reg[AXIS_Y];
            res_reg.a_z         <= nv_reg[AXIS_Z];
            res_reg.b_x         <= np_reg[AXIS_X];
            res_reg.b_y         <= np_reg[AXIS_Y];
            res_reg.b_z         <= np_reg[AXIS_Z];
            res_reg.run_end     <= cmd.pt_end;
        end
        else if (cmd.out_box)
        begin
            res_reg.result_kind <= KIND_BOX;
            res_reg.a_x         <= lo_reg[AXIS_X];
            res_reg.a_y         <= lo_reg[AXIS_Y];
            res_reg.a_z         <= lo_reg[AXIS_Z];
            res_reg.b_x         <= hi_reg[AXIS_X];
            res_reg.b_y         <= hi_reg[AXIS_Y];
            res_reg.b_z         <= hi_reg[AXIS_Z];
            res_reg.run_end     <= 1'b1;
        end
    end

    // running box, seeded from the old position of a first point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
            begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
        end
        else if (cmd.load && pt.first_point)
        begin
            lo_reg[AXIS_X] <= pt.pos_x;
            lo_reg[AXIS_Y] <= pt.pos_y;
            lo_reg[AXIS_Z] <= pt.pos_z;
            hi_reg[AXIS_X] <= pt.pos_x;
            hi_reg[AXIS_Y] <= pt.pos_y;
            hi_reg[AXIS_Z] <= pt.pos_z;
        end
        else if (cmd.wr_np)
        begin
            if (acc_sat > hi_reg[cmd.wr_axis])
            begin
                hi_reg[cmd.wr_axis] <= acc_sat;
            end
            if (acc_sat < lo_reg[cmd.wr_axis])
            begin
                lo_reg[cmd.wr_axis] <= acc_sat;
            end
        end
    end

    assign res = res_reg;

endmodule

// ----- rtl/mass_point_euler_integrator.sv -----
// top level of the mass point integrator: config registers, sequencer
// and datapath; depends on mpei_pkg, mpei_stream_if, mpei_cfg, mpei_ctrl, mpei_dp

// Semi-implicit Euler step for one mass point per item, all values signed
// Q16.16 (FRAC_BITS fractional bits). One 33x32 multiplier is shared over
// the whole update, so an item is worked on alone: after acceptance the
// sequencer steps through three force products, three velocity products,
// gap setup, the floor bounce product and the bounce write-back, then
// moves the point item into the output register, followed by the box item
// when the point closes a pass. The output register decouples the sink:
// the next item is accepted while the last result still waits, and only
// a second result stalls on it. New velocity is v + f*step_per_mass, new
// position p + v'*time_step, each product floored and each result
// saturated; a point landing strictly below floor_height gets its vertical
// velocity replaced by (floor - y)*inverse_step. The running box is kept
// over new positions, seeded from the old position of a first point, and
// sent as a second item (result_kind 1, run_end 1) after a last point.
// Registers sit on an APB-style port at byte addresses 0, 4, 8 and 12; the
// user must write them only while the block is idle, which the block
// itself does not enforce.

module mass_point_euler_integrator
    import mpei_pkg::*;
#(
    parameter int FRAC_BITS = MPEI_FRAC_BITS
) (
    input  logic              clk,
    input  logic              rst_n,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // item channels
    mpei_stream_if.sink       point,
    mpei_stream_if.source     result
);

    cfg_t    cfg;
    dp_cmd_t cmd;
    point_t  pt;
    result_t res;
    logic    in_ready;
    logic    out_valid;

    assign pt = point.data;

    mpei_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // sequencer: accepts a point, steps the multiplier, hands out results
    mpei_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (point.valid),
        .in_last   (pt.last_point),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (result.ready),
        .cmd       (cmd)
    );

    // datapath: operand capture, shared multiplier, box, output register
    mpei_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .pt    (pt),
        .cfg   (cfg),
        .res   (res)
    );

    assign point.ready  = in_ready;
    assign result.valid = out_valid;
    assign result.data  = res;

endmodule

// ----- rtl/mpei_chk.sv -----
// port-level checker of the mass point integrator and its bind
// depends on mpei_pkg and mass_point_euler_integrator

module mpei_chk
    import mpei_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data
);

    // a stalled result item stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    // a stalled result item keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_data))
        else $error("result payload changed while stalled");

    // a box item always closes its run
    a_box_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.result_kind == KIND_BOX) |-> out_data.run_end)
        else $error("box item without run_end");

    // one point in flight: ready drops right after an acceptance
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second point accepted while busy");

endmodule

bind mass_point_euler_integrator mpei_chk u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (point.valid),
    .in_ready  (point.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_data  (result.data)
);

// ----- dv/tb_mass_point_euler_integrator.sv -----
`timescale 1ns / 100ps
// self-checking testbench of mass_point_euler_integrator: directed and random
// mass points, config rewritten between passes; depends on mpei_pkg, mpei_stream_if

module tb_mass_point_euler_integrator
    import mpei_pkg::*;
();

    localparam int FRAC          = MPEI_FRAC_BITS;
    localparam int SETTLE_CYCLES = 24;      // wait after the last result before the next phase
    localparam int STALL_LIMIT   = 3000;    // cycles with no handshake of any kind
    localparam int BACKLOG_HOLD  = 400;     // one long sink hold-off to back up the block
    localparam int PHASE_POINTS  = 225;     // random points per setting, six settings
    localparam int PRINT_CAP     = 30;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // apb-style config port
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    mpei_stream_if #(.payload_t(point_t))  point_ch ();
    mpei_stream_if #(.payload_t(result_t)) result_ch ();

    mass_point_euler_integrator #(
        .FRAC_BITS (FRAC)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .point   (point_ch),
        .result  (result_ch)
    );

    // stimulus and expectations
    point_t  points_to_send [$];
    result_t results_owed [$];

    // shadow of the block: register values and the running box
    cfg_t               regs_now;
    logic signed [31:0] hull_lo [AXES] = '{default: 0};
    logic signed [31:0] hull_hi [AXES] = '{default: 0};

    // idling control, set per phase by the sequence below
    bit idle_mode     = 1'b0;
    bit backlog_hold  = 1'b0;
    bit backlog_done  = 1'b0;
    int send_gap      = 0;
    int sink_stall    = 0;
    int sink_pick     = 0;
    int quiet_cycles  = 0;
    int fail_count    = 0;

    initial
    begin
        forever #4 clk = ~clk;
    end

    // gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (!idle_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // saturate a wide sum to the q16.16 range
    function automatic logic signed [31:0] clamp_q16(input longint x);
        if (x > longint'(32'sh7FFF_FFFF))
            return S32_MAX;
        if (x < -longint'(32'sh8000_0000) - 1 + 1 - 64'sd0 && x < -64'sd2147483648)
            return S32_MIN;
        return x[31:0];
    endfunction

    // one euler step of a point plus the running box; queues what the block owes
    function automatic void integrate_point(input point_t pt);
        logic signed [31:0] f [AXES];
        logic signed [31:0] v [AXES];
        logic signed [31:0] p [AXES];
        logic signed [31:0] nv [AXES];
        logic signed [31:0] np [AXES];
        longint             delta;
        longint             gap;
        logic [63:0]        lift;
        result_t            upd;
        result_t            box;
        int                 i;

        f = '{pt.force_x, pt.force_y, pt.force_z};
        v = '{pt.vel_x, pt.vel_y, pt.vel_z};
        p = '{pt.pos_x, pt.pos_y, pt.pos_z};

        // a first point seeds the box from its old position
        if (pt.first_point)
        begin
            hull_lo = p;
            hull_hi = p;
        end

        for (i = 0; i < AXES; i++)
        begin
            // products are floored by the arithmetic shift
            delta = (longint'(f[i]) * longint'(regs_now.step_per_mass)) >>> FRAC;
            nv[i] = clamp_q16(longint'(v[i]) + delta);
            delta = (longint'(nv[i]) * longint'(regs_now.time_step)) >>> FRAC;
            np[i] = clamp_q16(longint'(p[i]) + delta);
            if (np[i] > hull_hi[i])
                hull_hi[i] = np[i];
            if (np[i] < hull_lo[i])
                hull_lo[i] = np[i];
        end

        // strictly below the floor: vertical velocity pushes back up
        if (np[AXIS_Y] < regs_now.floor_height)
        begin
            gap  = longint'(regs_now.floor_height) - longint'(np[AXIS_Y]);
            lift = gap;
            lift = (lift * {33'd0, regs_now.inverse_step}) >> FRAC;
            nv[AXIS_Y] = (lift > 64'h7FFF_FFFF) ? S32_MAX : lift[31:0];
        end

        upd.result_kind = KIND_POINT;
        upd.a_x         = nv[0];
        upd.a_y         = nv[1];
        upd.a_z         = nv[2];
        upd.b_x         = np[0];
        upd.b_y         = np[1];
        upd.b_z         = np[2];
        upd.run_end     = !pt.last_point;
        results_owed = {results_owed, upd};

        if (pt.last_point)
        begin
            box.result_kind = KIND_BOX;
            box.a_x         = hull_lo[0];
            box.a_y         = hull_lo[1];
            box.a_z         = hull_lo[2];
            box.b_x         = hull_hi[0];
            box.b_y         = hull_hi[1];
            box.b_z         = hull_hi[2];
            box.run_end     = 1'b1;
            results_owed = {results_owed, box};
        end
    endfunction

    // coordinates: full range, small values around the floor, the extremes
    function automatic logic signed [31:0] random_q16();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
            7:          return S32_MAX;
            8:          return S32_MIN;
            default:    return int'($urandom_range(0, 510)) - 255;
        endcase
    endfunction

    function automatic logic [30:0] random_coef();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6: return 31'($urandom_range(0, 32'h0004_0000));
            7, 8:                return 31'($urandom_range(0, 32'h0100_0000));
            default:             return 31'($urandom);
        endcase
    endfunction

    function automatic point_t random_point(input bit first, input bit last);
        point_t pt;
        pt.first_point = first;
        pt.last_point  = last;
        pt.force_x     = random_q16();
        pt.force_y     = random_q16();
        pt.force_z     = random_q16();
        pt.vel_x       = random_q16();
        pt.vel_y       = random_q16();
        pt.vel_z       = random_q16();
        pt.pos_x       = random_q16();
        pt.pos_y       = random_q16();
        pt.pos_z       = random_q16();
        return pt;
    endfunction

    // same value on all three axes
    function automatic point_t even_point(input bit first, input bit last,
                                          input logic signed [31:0] f,
                                          input logic signed [31:0] v,
                                          input logic signed [31:0] p);
        point_t pt;
        pt.first_point = first;
        pt.last_point  = last;
        pt.force_x     = f;
        pt.force_y     = f;
        pt.force_z     = f;
        pt.vel_x       = v;
        pt.vel_y       = v;
        pt.vel_z       = v;
        pt.pos_x       = p;
        pt.pos_y       = p;
        pt.pos_z       = p;
        return pt;
    endfunction

    // setup cycle, then access cycle; the register takes the value at the access edge
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_TIME_STEP:     regs_now.time_step     = value[30:0];
            REG_STEP_PER_MASS: regs_now.step_per_mass = value[30:0];
            REG_INVERSE_STEP:  regs_now.inverse_step  = value[30:0];
            REG_FLOOR_HEIGHT:  regs_now.floor_height  = value;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input logic [30:0] step, input logic [30:0] per_mass,
                                  input logic [30:0] inv, input logic signed [31:0] flr);
        write_reg(REG_TIME_STEP, {1'b0, step});
        write_reg(REG_STEP_PER_MASS, {1'b0, per_mass});
        write_reg(REG_INVERSE_STEP, {1'b0, inv});
        write_reg(REG_FLOOR_HEIGHT, flr);
    endtask

    // mostly whole passes (first .. last) with random content, some loose points
    task automatic queue_passes(input int count);
        int queued;
        int len;
        int k;
        queued = 0;
        while (queued < count)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                  : $urandom_range(1, 12);
                for (k = 0; k < len; k++)
                    points_to_send = {points_to_send,
                                      random_point(k == 0, k == len - 1)};
                queued += len;
            end
            else
            begin
                points_to_send = {points_to_send,
                                  random_point(1'($urandom_range(0, 1)),
                                               1'($urandom_range(0, 1)))};
                queued++;
            end
        end
    endtask

    // block idle: everything sent, every result back, pipeline flushed
    // sampled on the falling edge so that the driver's updates have settled
    task automatic drain();
        while (points_to_send.size() != 0 || point_ch.valid || results_owed.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // point driver: one item per handshake, random gap after each
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_ch.valid <= 1'b0;
            send_gap       <= 0;
        end
        else
        begin
            if (point_ch.valid && point_ch.ready)
                integrate_point(point_ch.data);
            if (!point_ch.valid || point_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    point_ch.valid <= 1'b0;
                    send_gap       <= send_gap - 1;
                end
                else if (points_to_send.size() != 0)
                begin
                    point_ch.data  <= points_to_send.pop_front();
                    point_ch.valid <= 1'b1;
                    send_gap       <= pick_gap();
                end
                else
                begin
                    point_ch.valid <= 1'b0;
                end
            end
        end
    end

    // result sink: random stalls, plus one long hold-off when asked
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            sink_stall      <= 0;
        end
        else if (backlog_hold && !backlog_done)
        begin
            result_ch.ready <= 1'b0;
            sink_stall      <= BACKLOG_HOLD;
            backlog_done    <= 1'b1;
        end
        else if (sink_stall > 0)
        begin
            result_ch.ready <= 1'b0;
            sink_stall      <= sink_stall - 1;
        end
        else
        begin
            sink_pick = pick_gap();
            result_ch.ready <= (sink_pick == 0);
            sink_stall      <= (sink_pick > 0) ? sink_pick - 1 : 0;
        end
    end

    // result checker: each item against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (results_owed.size() == 0)
            begin
                fail_count++;
                if (fail_count <= PRINT_CAP)
                    $display("%0t: unexpected result item kind %0d a %h %h %h b %h %h %h end %0d",
                             $time, result_ch.data.result_kind, result_ch.data.a_x,
                             result_ch.data.a_y, result_ch.data.a_z, result_ch.data.b_x,
                             result_ch.data.b_y, result_ch.data.b_z, result_ch.data.run_end);
            end
            else if (result_ch.data !== results_owed[0])
            begin
                fail_count++;
                if (fail_count <= PRINT_CAP)
                    $display({"%0t: mismatch, expected kind %0d a %h %h %h b %h %h %h end %0d,",
                              " actual kind %0d a %h %h %h b %h %h %h end %0d"},
                             $time, results_owed[0].result_kind, results_owed[0].a_x,
                             results_owed[0].a_y, results_owed[0].a_z, results_owed[0].b_x,
                             results_owed[0].b_y, results_owed[0].b_z, results_owed[0].run_end,
                             result_ch.data.result_kind, result_ch.data.a_x,
                             result_ch.data.a_y, result_ch.data.a_z, result_ch.data.b_x,
                             result_ch.data.b_y, result_ch.data.b_z, result_ch.data.run_end);
                void'(results_owed.pop_front());
            end
            else
            begin
                void'(results_owed.pop_front());
            end
        end
    end

    // watchdog: a long run of cycles with no handshake on any port means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((point_ch.valid && point_ch.ready) || (result_ch.valid && result_ch.ready)
                || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        point_t pt;

        point_ch.valid  = 1'b0;
        point_ch.data   = '0;
        result_ch.ready = 1'b0;

        regs_now.time_step     = TIME_STEP_RST;
        regs_now.step_per_mass = STEP_PER_MASS_RST;
        regs_now.inverse_step  = INVERSE_STEP_RST;
        regs_now.floor_height  = FLOOR_HEIGHT_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed points at reset settings, no idling
        // box never seeded: it grows from zero
        points_to_send = {points_to_send, even_point(0, 0, 32'sh0001_0000,
                                                     32'sh0002_0000, 32'sh0003_0000)};
        points_to_send = {points_to_send, even_point(0, 1, 0, 0, -32'sh0003_0000)};
        points_to_send = {points_to_send, even_point(1, 0, 0, 0, 0)};
        // saturation both ways, the low one also bounces with a clipped velocity
        points_to_send = {points_to_send, even_point(0, 0, S32_MAX, S32_MAX, S32_MAX)};
        points_to_send = {points_to_send, even_point(0, 0, S32_MIN, S32_MIN, S32_MIN)};
        // smallest negative force floors to minus one lsb
        points_to_send = {points_to_send, even_point(0, 1, -32'sd1, 0, 0)};
        // one lsb below the floor, then exactly on it
        pt = even_point(1, 0, 0, 0, 0);
        pt.pos_y = -32'sd65537;
        points_to_send = {points_to_send, pt};
        pt = even_point(0, 0, 0, 0, 0);
        pt.pos_y = -32'sd65536;
        points_to_send = {points_to_send, pt};
        // first and last on the same point
        points_to_send = {points_to_send, even_point(1, 1, 0, -32'sh0001_0000,
                                                     32'sh0005_0000)};
        // alternating bit patterns
        points_to_send = {points_to_send, even_point(0, 0, 32'shAAAA_AAAA,
                                                     32'sh5555_5555, 32'shAAAA_AAAA)};
        points_to_send = {points_to_send, even_point(0, 1, 32'sh5555_5555,
                                                     32'shAAAA_AAAA, 32'sh5555_5555)};
        // mixed signs across axes
        pt = even_point(1, 0, 0, 0, 0);
        pt.force_x = S32_MAX;
        pt.force_y = S32_MIN;
        pt.vel_x   = S32_MIN;
        pt.vel_z   = S32_MAX;
        pt.pos_x   = S32_MAX;
        pt.pos_z   = S32_MIN;
        points_to_send = {points_to_send, pt};
        points_to_send = {points_to_send, even_point(0, 1, 1, 1, 1)};
        // a second seed inside an open pass restarts the box
        points_to_send = {points_to_send, even_point(1, 0, 32'sh0001_0000, 0,
                                                     32'sh0007_0000)};
        points_to_send = {points_to_send, even_point(1, 0, 0, 32'sh0000_8000,
                                                     -32'sh0002_0000)};
        points_to_send = {points_to_send, even_point(0, 1, 0, 0, 0)};
        drain();

        // unit step, mass and reciprocal, floor at zero
        apply_settings(31'h0001_0000, 31'h0001_0000, 31'h0001_0000, 32'sd0);
        idle_mode = 1'b1;
        queue_passes(PHASE_POINTS);
        drain();

        // every register at its top value
        apply_settings(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, S32_MAX);
        idle_mode = 1'b0;
        queue_passes(PHASE_POINTS);
        drain();

        // usual simulation values; the sink holds off long enough to back up the block
        apply_settings(31'd655, 31'd1310, 31'd6553600, -32'sh0001_0000);
        idle_mode    = 1'b1;
        backlog_hold = 1'b1;
        queue_passes(PHASE_POINTS);
        drain();

        // every register at its bottom value
        apply_settings(31'd0, 31'd0, 31'd0, S32_MIN);
        idle_mode = 1'b1;
        queue_passes(PHASE_POINTS);
        drain();

        // random settings, once without idling and once with
        apply_settings(random_coef(), random_coef(), random_coef(), random_q16());
        idle_mode = 1'b0;
        queue_passes(PHASE_POINTS);
        drain();

        apply_settings(random_coef(), random_coef(), random_coef(), random_q16());
        idle_mode = 1'b1;
        queue_passes(PHASE_POINTS);
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
